/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/lruto_pkg.sv */
`default_nettype none
package lruto_pkg;
    localparam int DefEntries  = 64;
    localparam int DefTimeBits = 32;
    localparam int IdBits      = 6;
    localparam int OpBits      = 2;
    localparam int CfgBits     = 32;
    localparam logic [CfgBits-1:0] ExpireReset = 32'd10;

    localparam logic [OpBits-1:0] OP_REGISTER = 2'd0;
    localparam logic [OpBits-1:0] OP_TOUCH    = 2'd1;
    localparam logic [OpBits-1:0] OP_CHECK    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOUCH_RD,
        ST_TOUCH_WR,
        ST_CHECK_RD,
        ST_CHECK_CMP,
        ST_CHECK_FIX,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

/* hw/rtl/lruto_ram.sv */
`default_nettype none
module lruto_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                      clk,
    input  wire                      wr_en,
    input  wire [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire [WIDTH-1:0]          wr_data,
    input  wire [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

/* hw/rtl/lru_idle_timeout_list_unit.sv */
// Idle-timeout list: ids are kept in least-recently-touched order in a doubly
// linked list held in small RAMs. A register or an unknown touch is answered
// directly; a touch of a known id reads, then patches its links. A check on
// an empty list is answered directly; one that finds a fresh head reads and
// compares it first. A check that removes expired ids walks from the head:
// each removal reads the head's stamp and link from RAM, compares the age in
// one shared subtract/compare unit, and holds the removed id until the next
// head is compared, so that the last flag is known before the result is shown.
// One result is held in an output register, also while out_stall is high; the
// block is not ready again until the last result of an item is transferred.
`default_nettype none
module lru_idle_timeout_list_unit
    import lruto_pkg::*;
#(
    parameter int ENTRIES   = DefEntries,
    parameter int TIME_BITS = DefTimeBits
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire [OpBits-1:0]   operation,
    input  wire [IdBits-1:0]   entry_id,
    input  wire [31:0]         now_time,
    output logic               out_valid,
    input  wire                out_stall,
    output logic [IdBits-1:0]  expired_id,
    output logic               is_expired,
    output logic               unknown_id,
    output logic               last,
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire [CfgBits-1:0]  cfg_data
);
    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int TW = (TIME_BITS < 32) ? TIME_BITS : 32;

    state_t state_reg, state_next;
    logic [ENTRIES-1:0] known_reg, known_next;
    logic [ENTRIES-1:0] listed_reg, listed_next;
    logic [AW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CfgBits-1:0] expire_reg;
    logic [AW-1:0] id_reg, id_next;
    logic [TW-1:0] now_reg, now_next;
    logic [IdBits-1:0] oid_reg, oid_next;
    logic oexp_reg, oexp_next, ounk_reg, ounk_next, olast_reg, olast_next;
    logic [AW-1:0] nxt_reg, nxt_next;

    // RAM ports
    logic st_we, nl_we, pl_we;
    logic [AW-1:0] st_wa, nl_wa, pl_wa, rd_a;
    logic [TW-1:0] st_wd, st_rd;
    logic [AW-1:0] nl_wd, pl_wd, nl_rd, pl_rd;

    lruto_ram #(.WIDTH(TW), .DEPTH(ENTRIES)) u_stamp (
        .clk(clk), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
        .rd_addr(rd_a), .rd_data(st_rd));
    lruto_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_next (
        .clk(clk), .wr_en(nl_we), .wr_addr(nl_wa), .wr_data(nl_wd),
        .rd_addr(rd_a), .rd_data(nl_rd));
    lruto_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_prev (
        .clk(clk), .wr_en(pl_we), .wr_addr(pl_wa), .wr_data(pl_wd),
        .rd_addr(rd_a), .rd_data(pl_rd));

    // Shared age compare
    logic [TW-1:0] age;
    logic expired_w;
    assign age = now_reg - st_rd;
    assign expired_w = {{(64-TW){1'b0}}, age} > {32'd0, expire_reg};

    assign in_stall   = (state_reg != ST_IDLE);
    assign cfg_ready  = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_OUT);
    assign expired_id = oid_reg;
    assign is_expired = oexp_reg;
    assign unknown_id = ounk_reg;
    assign last       = olast_reg;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            known_reg  <= '0;
            listed_reg <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            expire_reg <= ExpireReset;
        end
        else
        begin
            state_reg  <= state_next;
            known_reg  <= known_next;
            listed_reg <= listed_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                expire_reg <= cfg_data;
            end
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        now_reg   <= now_next;
        oid_reg   <= oid_next;
        oexp_reg  <= oexp_next;
        ounk_reg  <= ounk_next;
        olast_reg <= olast_next;
        nxt_reg   <= nxt_next;
    end

    // Sequence one item
    always_comb
    begin
        logic [AW-1:0] nid;
        logic in_range;
        state_next  = state_reg;
        known_next  = known_reg;
        listed_next = listed_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        id_next     = id_reg;
        now_next    = now_reg;
        oid_next    = oid_reg;
        oexp_next   = oexp_reg;
        ounk_next   = ounk_reg;
        olast_next  = olast_reg;
        nxt_next    = nxt_reg;
        st_we = 1'b0; st_wa = id_reg; st_wd = now_reg;
        nl_we = 1'b0; nl_wa = tail_reg; nl_wd = id_reg;
        pl_we = 1'b0; pl_wa = id_reg; pl_wd = tail_reg;
        rd_a  = id_reg;
        nid      = entry_id[AW-1:0];
        in_range = ({26'd0, entry_id} < ENTRIES);

        unique case (state_reg)
            ST_IDLE:
            begin
                rd_a = nid;
                if (in_valid)
                begin
                    id_next    = nid;
                    now_next   = now_time[TW-1:0];
                    oid_next   = '0;
                    oexp_next  = 1'b0;
                    ounk_next  = 1'b0;
                    olast_next = 1'b1;
                    state_next = ST_OUT;
                    if (operation == OP_REGISTER)
                    begin
                        if (in_range)
                        begin
                            known_next[nid] = 1'b1;
                        end
                    end
                    else if (operation == OP_TOUCH)
                    begin
                        if (!in_range || !known_reg[nid])
                        begin
                            ounk_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_TOUCH_RD;
                        end
                    end
                    else if (operation == OP_CHECK)
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = ST_CHECK_RD;
                        end
                    end
                end
            end
            ST_TOUCH_RD:
            begin
                // Links of id are on the RAM outputs; unlink it
                if (listed_reg[id_reg])
                begin
                    if (count_reg <= 1)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        if (id_reg == head_reg)
                        begin
                            head_next = nl_rd;
                        end
                        else
                        begin
                            nl_we = 1'b1; nl_wa = pl_rd; nl_wd = nl_rd;
                        end
                        if (id_reg == tail_reg)
                        begin
                            tail_next = pl_rd;
                        end
                        else
                        begin
                            pl_we = 1'b1; pl_wa = nl_rd; pl_wd = pl_rd;
                        end
                        count_next = count_reg - 1'b1;
                    end
                end
                state_next = ST_TOUCH_WR;
            end
            ST_TOUCH_WR:
            begin
                // Append at tail and stamp
                if (count_reg == '0)
                begin
                    head_next = id_reg;
                end
                else
                begin
                    nl_we = 1'b1; nl_wa = tail_reg; nl_wd = id_reg;
                    pl_we = 1'b1; pl_wa = id_reg; pl_wd = tail_reg;
                end
                st_we = 1'b1;
                tail_next = id_reg;
                count_next = count_reg + 1'b1;
                listed_next[id_reg] = 1'b1;
                state_next = ST_OUT;
            end
            ST_CHECK_RD:
            begin
                rd_a = head_reg;
                state_next = ST_CHECK_CMP;
            end
            ST_CHECK_CMP:
            begin
                if (count_reg != '0 && expired_w)
                begin
                    // Head expires: show a held removal first, with last low
                    nxt_next = nl_rd;
                    if (oexp_reg)
                    begin
                        olast_next = 1'b0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_CHECK_FIX;
                    end
                end
                else
                begin
                    // Fresh head or empty list ends the walk
                    olast_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_CHECK_FIX:
            begin
                // Unlink the head and hold it as the next result
                listed_next[head_reg] = 1'b0;
                oid_next  = IdBits'(head_reg);
                oexp_next = 1'b1;
                if (count_reg <= 1)
                begin
                    count_next = '0;
                    head_next  = '0;
                    tail_next  = '0;
                end
                else
                begin
                    head_next  = nxt_reg;
                    count_next = count_reg - 1'b1;
                end
                state_next = ST_CHECK_RD;
            end
            ST_OUT:
            begin
                rd_a = head_reg;
                if (!out_stall)
                begin
                    if (olast_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_CHECK_FIX;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

/* hw/rtl/lruto_checker.sv */
`default_nettype none
module lruto_checker
    import lruto_pkg::*;
(
    input wire                clk,
    input wire                rst_n,
    input wire                in_valid,
    input wire                in_stall,
    input wire                out_valid,
    input wire                out_stall,
    input wire [IdBits-1:0]   expired_id,
    input wire                is_expired,
    input wire                unknown_id,
    input wire                last,
    input wire                cfg_ready
);
`include "assert_macros.svh"
    `CHK_IMPLY(a_unk_last, clk, rst_n, out_valid && unknown_id, last && !is_expired, "unknown not final")
    `CHK_IMPLY(a_noexp_id, clk, rst_n, out_valid && !is_expired, expired_id == '0, "id without expiry")
    `CHK_IMPLY(a_busy_out, clk, rst_n, out_valid, in_stall && !cfg_ready, "input open while result pending")
    `CHK_NEXT(a_stall_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(expired_id), "result dropped")
    `CHK_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall, "input open after transfer")
endmodule

bind lru_idle_timeout_list_unit lruto_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .expired_id(expired_id),
    .is_expired(is_expired), .unknown_id(unknown_id), .last(last),
    .cfg_ready(cfg_ready));
`default_nettype wire
